// File: hw/rtl/rspt_pkg.sv
// rspt_pkg: shared widths, opcodes and register indexes of the summed area table block
// used by rectangle_sum_prefix_table_top and its port checker; no dependencies
`default_nettype none
package rspt_pkg;

  // fixed field widths
  localparam int POS_W     = 6;   // rectangle corner fields
  localparam int CFG_W     = 7;   // row_count / col_count registers
  localparam int CFG_IDX_W = 2;   // register index port
  localparam int TABLE_W   = 29;  // prefix table entries and running sum
  localparam int SUM_W     = 28;  // rectangle sum

  // parameter defaults
  localparam int DEF_MAX_ROWS      = 64;
  localparam int DEF_MAX_COLS      = 64;
  localparam int DEF_ELEMENT_WIDTH = 16;
  localparam int DIM_RESET         = 64;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

endpackage
`default_nettype wire

// File: hw/rtl/rectangle_sum_prefix_table_top.sv
// rectangle_sum_prefix_table_top: summed area table built in one synchronous memory
// depends on rspt_pkg
//
// usage:
//   input channel: an item transfers at a rising edge with start high and busy low.
//   in_op = OP_LOAD brings the next matrix element in raster order, in_op = OP_QUERY
//   asks for the sum over the rectangle top_row..bottom_row x left_col..right_col.
//   result channel: one result per query, shown for exactly one cycle with
//   out_valid high; the receiver cannot stall it, so nothing ever waits for it.
//   config port: cfg_we writes register cfg_index (row_count, col_count) with
//   cfg_data at once; a write to either register restarts loading of the table.
// timing:
//   a load keeps busy high through S_LD_RD (read of the entry above) and S_LD_WR
//   (the write), so the single memory port takes no new load until both are done.
//   a valid query issues its four table reads on the one port, one a cycle, and
//   accumulates; busy stays high until the sum is registered, and out_valid rises
//   as busy falls, so a new query is taken only after the last one is answered.
//   a rejected query (bad corners or incomplete table) is answered the cycle after
//   the transfer with busy staying low.
// reset: loading restarts at row 0, column 0, table marked incomplete, both sizes
//   at 64 (limited to the maximum). the table memory is not cleared; a query only
//   ever reads a complete table.
`default_nettype none
module rectangle_sum_prefix_table_top #(
  parameter int MAX_ROWS      = rspt_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS      = rspt_pkg::DEF_MAX_COLS,
  parameter int ELEMENT_WIDTH = rspt_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic signed [ELEMENT_WIDTH-1:0]     in_element_value,
  input  logic [rspt_pkg::POS_W-1:0]          in_top_row,
  input  logic [rspt_pkg::POS_W-1:0]          in_left_col,
  input  logic [rspt_pkg::POS_W-1:0]          in_bottom_row,
  input  logic [rspt_pkg::POS_W-1:0]          in_right_col,
  output logic                                out_valid,
  output logic signed [rspt_pkg::SUM_W-1:0]   out_rect_sum,
  output logic                                out_query_error,
  input  logic                                cfg_we,
  input  logic [rspt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rspt_pkg::CFG_W-1:0]          cfg_data
);
  import rspt_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_QUERY
  } state_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) res = CFG_W'(1);
    else if (int'(v) > maxv) res = CFG_W'(maxv);
    return res;
  endfunction

  function automatic logic [AW-1:0] tbl_addr(input logic [CFG_W-1:0] r,
                                             input logic [CFG_W-1:0] c);
    int a;
    a = int'(r) * MAX_COLS + int'(c);
    return AW'(a);
  endfunction

  // table memory
  logic [TABLE_W-1:0] mem [DEPTH];
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [TABLE_W-1:0] mem_wdata;
  logic [TABLE_W-1:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic [CFG_W-1:0]   col_cnt_r, col_cnt_nxt;
  logic [CFG_W-1:0]   load_row_r, load_row_nxt;
  logic [CFG_W-1:0]   load_col_r, load_col_nxt;
  logic [TABLE_W-1:0] run_sum_r, run_sum_nxt;
  logic               complete_r, complete_nxt;
  logic [POS_W-1:0]   q_top_r, q_top_nxt;
  logic [POS_W-1:0]   q_left_r, q_left_nxt;
  logic [POS_W-1:0]   q_bottom_r, q_bottom_nxt;
  logic [POS_W-1:0]   q_right_r, q_right_nxt;
  logic [2:0]         q_cnt_r, q_cnt_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]   out_sum_r, out_sum_nxt;
  logic               out_err_r, out_err_nxt;

  logic               accept;
  logic               restart;
  logic [CFG_W-1:0]   eff_row, eff_col;
  logic [TABLE_W-1:0] run_base;
  logic [TABLE_W-1:0] elem_ext;
  logic               q_bad;
  logic               top_nz, left_nz;
  logic [POS_W-1:0]   top_m1, left_m1;
  logic [SUM_W-1:0]   term;
  logic [SUM_W-1:0]   acc_sum;

  assign accept   = start && (state_r == S_IDLE);
  assign elem_ext = TABLE_W'(in_element_value);

  // a stale position (sizes shrunk under it) starts a new table
  assign restart  = (load_row_r >= row_cnt_r) || (load_col_r >= col_cnt_r);
  assign eff_row  = restart ? '0 : load_row_r;
  assign eff_col  = restart ? '0 : load_col_r;
  assign run_base = restart ? '0 : run_sum_r;

  assign q_bad = !complete_r || (in_top_row > in_bottom_row) || (in_left_col > in_right_col) ||
                 ({1'b0, in_bottom_row} >= row_cnt_r) || ({1'b0, in_right_col} >= col_cnt_r);

  assign top_nz  = (q_top_r != '0);
  assign left_nz = (q_left_r != '0);
  assign top_m1  = top_nz ? q_top_r - POS_W'(1) : '0;
  assign left_m1 = left_nz ? q_left_r - POS_W'(1) : '0;

  // signed contribution of the read that returned this cycle
  always_comb begin
    term = '0;
    unique case (q_cnt_r)
      3'd1:    term = mem_rdata_r[SUM_W-1:0];
      3'd2:    term = left_nz ? -mem_rdata_r[SUM_W-1:0] : '0;
      3'd3:    term = top_nz ? -mem_rdata_r[SUM_W-1:0] : '0;
      3'd4:    term = (top_nz && left_nz) ? mem_rdata_r[SUM_W-1:0] : '0;
      default: term = '0;
    endcase
  end
  assign acc_sum = acc_r + term;

  // memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = run_sum_r + ((load_row_r != '0) ? mem_rdata_r : '0);
    mem_addr  = '0;
    unique case (state_r)
      S_LD_RD: begin
        mem_addr = tbl_addr((load_row_r != '0) ? load_row_r - CFG_W'(1) : load_row_r,
                            load_col_r);
      end
      S_LD_WR: begin
        mem_we   = 1'b1;
        mem_addr = tbl_addr(load_row_r, load_col_r);
      end
      S_QUERY: begin
        unique case (q_cnt_r)
          3'd0:    mem_addr = tbl_addr({1'b0, q_bottom_r}, {1'b0, q_right_r});
          3'd1:    mem_addr = tbl_addr({1'b0, q_bottom_r}, {1'b0, left_m1});
          3'd2:    mem_addr = tbl_addr({1'b0, top_m1}, {1'b0, q_right_r});
          3'd3:    mem_addr = tbl_addr({1'b0, top_m1}, {1'b0, left_m1});
          default: mem_addr = '0;
        endcase
      end
      default: mem_addr = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    load_row_nxt  = load_row_r;
    load_col_nxt  = load_col_r;
    run_sum_nxt   = run_sum_r;
    complete_nxt  = complete_r;
    q_top_nxt     = q_top_r;
    q_left_nxt    = q_left_r;
    q_bottom_nxt  = q_bottom_r;
    q_right_nxt   = q_right_r;
    q_cnt_nxt     = q_cnt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    out_err_nxt   = out_err_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_LOAD) begin
            load_row_nxt = eff_row;
            load_col_nxt = eff_col;
            run_sum_nxt  = run_base + elem_ext;
            complete_nxt = 1'b0;
            state_nxt    = S_LD_RD;
          end else if (q_bad) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = '0;
            out_err_nxt   = 1'b1;
          end else begin
            q_top_nxt    = in_top_row;
            q_left_nxt   = in_left_col;
            q_bottom_nxt = in_bottom_row;
            q_right_nxt  = in_right_col;
            q_cnt_nxt    = '0;
            acc_nxt      = '0;
            state_nxt    = S_QUERY;
          end
        end
      end
      S_LD_RD: begin
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        state_nxt = S_IDLE;
        if (load_col_r + CFG_W'(1) >= col_cnt_r) begin
          load_col_nxt = '0;
          run_sum_nxt  = '0;
          if (load_row_r + CFG_W'(1) >= row_cnt_r) begin
            load_row_nxt = '0;
            complete_nxt = 1'b1;
          end else begin
            load_row_nxt = load_row_r + CFG_W'(1);
          end
        end else begin
          load_col_nxt = load_col_r + CFG_W'(1);
        end
      end
      S_QUERY: begin
        acc_nxt   = acc_sum;
        q_cnt_nxt = q_cnt_r + 3'd1;
        if (q_cnt_r == 3'd4) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_sum;
          out_err_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // register writes must arrive only while idle (the block does not enforce this); size writes restart loading
    if (cfg_we && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT)) begin
      if (cfg_index == REG_ROW_COUNT) row_cnt_nxt = clamp_dim(cfg_data, MAX_ROWS);
      else                            col_cnt_nxt = clamp_dim(cfg_data, MAX_COLS);
      load_row_nxt = '0;
      load_col_nxt = '0;
      run_sum_nxt  = '0;
      complete_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_cnt_r   <= clamp_dim(CFG_W'(DIM_RESET), MAX_ROWS);
      col_cnt_r   <= clamp_dim(CFG_W'(DIM_RESET), MAX_COLS);
      load_row_r  <= '0;
      load_col_r  <= '0;
      run_sum_r   <= '0;
      complete_r  <= 1'b0;
      q_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      run_sum_r   <= run_sum_nxt;
      complete_r  <= complete_nxt;
      q_cnt_r     <= q_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_top_r    <= q_top_nxt;
    q_left_r   <= q_left_nxt;
    q_bottom_r <= q_bottom_nxt;
    q_right_r  <= q_right_nxt;
    acc_r      <= acc_nxt;
    out_sum_r  <= out_sum_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_rect_sum    = out_sum_r;
  assign out_query_error = out_err_r;

endmodule
`default_nettype wire

// File: hw/rtl/rspt_checker.sv
// rspt_checker: port-level checks of rectangle_sum_prefix_table_top over time, plus its bind
// depends on rspt_pkg
`default_nettype none
module rspt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              in_op,
  input logic                              out_valid,
  input logic signed [rspt_pkg::SUM_W-1:0] out_rect_sum,
  input logic                              out_query_error
);
  import rspt_pkg::*;

  logic xfer;
  assign xfer = start && !busy;

  // a result is only shown once the block has gone idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_query_error) |-> (out_rect_sum == '0))
    else $error("rejected query with nonzero sum");

  // a query is either answered at once or keeps the block busy
  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && in_op == OP_QUERY) |=> (out_valid || busy))
    else $error("query transfer went nowhere");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && in_op == OP_LOAD) |=> (busy && !out_valid))
    else $error("load transfer did not occupy the block");

endmodule

bind rectangle_sum_prefix_table_top rspt_checker u_rspt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_rect_sum    (out_rect_sum),
  .out_query_error (out_query_error)
);
`default_nettype wire

// File: sim/rectangle_sum_prefix_table_top_test.sv
// rectangle_sum_prefix_table_top_test: self-checking bench for the summed area table block
// random table loads, rectangle queries and size writes checked against an in-bench table
// depends on rspt_pkg and rectangle_sum_prefix_table_top
module rectangle_sum_prefix_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rspt_pkg::*;

  localparam int EW            = DEF_ELEMENT_WIDTH;
  localparam int MAX_R         = DEF_MAX_ROWS;
  localparam int MAX_C         = DEF_MAX_COLS;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_GOAL     = 1650;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    err;
  } rect_answer_t;

  typedef struct {
    bit                    is_reg;
    logic                  op;
    logic signed [EW-1:0]  elem;
    logic [POS_W-1:0]      top, left, bottom, right;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_val;
    int unsigned           gap_pct;
  } bench_op_t;

  logic                    clk = 1'b1;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_op = OP_LOAD;
  logic signed [EW-1:0]    in_element_value = '0;
  logic [POS_W-1:0]        in_top_row = '0;
  logic [POS_W-1:0]        in_left_col = '0;
  logic [POS_W-1:0]        in_bottom_row = '0;
  logic [POS_W-1:0]        in_right_col = '0;
  logic                    out_valid;
  logic signed [SUM_W-1:0] out_rect_sum;
  logic                    out_query_error;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = REG_ROW_COUNT;
  logic [CFG_W-1:0]        cfg_data = '0;

  rectangle_sum_prefix_table_top uut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------- table model ----------------
  logic signed [TABLE_W-1:0] sat_tbl [0:MAX_R*MAX_C-1];
  logic signed [TABLE_W-1:0] row_acc = '0;
  int unsigned ld_row = 0;
  int unsigned ld_col = 0;
  bit          tbl_full = 1'b0;
  int unsigned rows_used = (DIM_RESET > MAX_R) ? MAX_R : DIM_RESET;
  int unsigned cols_used = (DIM_RESET > MAX_C) ? MAX_C : DIM_RESET;

  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  task automatic restart_fill();
    row_acc  = '0;
    ld_row   = 0;
    ld_col   = 0;
    tbl_full = 1'b0;
  endtask

  task automatic apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == REG_ROW_COUNT) begin
      rows_used = clamp_size(val, MAX_R);
      restart_fill();
    end else if (idx == REG_COL_COUNT) begin
      cols_used = clamp_size(val, MAX_C);
      restart_fill();
    end
  endtask

  task automatic absorb_element(logic signed [EW-1:0] v);
    logic signed [TABLE_W-1:0] above;
    if (ld_row >= rows_used || ld_col >= cols_used) restart_fill();
    above = '0;
    if (ld_row != 0) above = sat_tbl[(ld_row - 1) * MAX_C + ld_col];
    row_acc = row_acc + v;
    sat_tbl[ld_row * MAX_C + ld_col] = row_acc + above;
    tbl_full = 1'b0;
    ld_col++;
    if (ld_col >= cols_used) begin
      ld_col  = 0;
      row_acc = '0;
      ld_row++;
      if (ld_row >= rows_used) begin
        ld_row   = 0;
        tbl_full = 1'b1;
      end
    end
  endtask

  function automatic rect_answer_t rect_answer(logic [POS_W-1:0] t, l, b, r);
    rect_answer_t a;
    longint       acc;
    a.sum = '0;
    a.err = 1'b1;
    if (!tbl_full || t > b || l > r || b >= rows_used || r >= cols_used) return a;
    acc = sat_tbl[b * MAX_C + r];
    // drop the terms that fall off the top or left edge
    if (l != 0) acc -= sat_tbl[b * MAX_C + l - 1];
    if (t != 0) acc -= sat_tbl[(t - 1) * MAX_C + r];
    if (t != 0 && l != 0) acc += sat_tbl[(t - 1) * MAX_C + l - 1];
    a.sum = acc[SUM_W-1:0];
    a.err = 1'b0;
    return a;
  endfunction

  // ---------------- stimulus ----------------
  bench_op_t   pending_ops[$];
  int unsigned items_queued = 0;

  task automatic push_item(logic op, logic signed [EW-1:0] v, logic [POS_W-1:0] t, l, b, r);
    bench_op_t s;
    s = '{default: 0};
    s.op     = op;
    s.elem   = v;
    s.top    = t;
    s.left   = l;
    s.bottom = b;
    s.right  = r;
    // rotate through no gaps, heavy gaps, no gaps, moderate gaps
    case ((items_queued / 200) % 4)
      1:       s.gap_pct = 72;
      3:       s.gap_pct = 34;
      default: s.gap_pct = 0;
    endcase
    items_queued++;
    pending_ops.push_back(s);
  endtask

  task automatic push_load(logic signed [EW-1:0] v);
    push_item(OP_LOAD, v, POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
              POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)));
  endtask

  task automatic push_query(logic [POS_W-1:0] t, l, b, r);
    push_item(OP_QUERY, EW'($urandom), t, l, b, r);
  endtask

  task automatic push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    bench_op_t s;
    s = '{default: 0};
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    pending_ops.push_back(s);
  endtask

  function automatic logic signed [EW-1:0] random_element();
    if ($urandom_range(0, 9) != 0) return EW'($urandom);
    case ($urandom_range(0, 3))
      0:       return {1'b1, {(EW-1){1'b0}}};
      1:       return {1'b0, {(EW-1){1'b1}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic push_rect_query(int unsigned nr, int unsigned nc);
    int unsigned t, l;
    if ($urandom_range(0, 99) < 85) begin
      t = $urandom_range(0, nr - 1);
      l = $urandom_range(0, nc - 1);
      push_query(POS_W'(t), POS_W'(l), POS_W'($urandom_range(t, nr - 1)),
                 POS_W'($urandom_range(l, nc - 1)));
    end else begin
      push_query(POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                 POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)));
    end
  endtask

  // resize, maybe query early, fill a whole table, maybe write a spare index, query it, sometimes reload part or all
  task automatic fill_round(logic [CFG_W-1:0] row_raw, logic [CFG_W-1:0] col_raw);
    int unsigned nr, nc, k, n;
    push_reg(REG_ROW_COUNT, row_raw);
    push_reg(REG_COL_COUNT, col_raw);
    nr = clamp_size(row_raw, MAX_R);
    nc = clamp_size(col_raw, MAX_C);
    if ($urandom_range(0, 3) == 0) push_rect_query(nr, nc);
    for (k = 0; k < nr * nc; k++) push_load(random_element());
    if ($urandom_range(0, 4) == 0)
      push_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
               CFG_W'($urandom_range(0, 127)));
    n = $urandom_range(8, 24);
    for (k = 0; k < n; k++) push_rect_query(nr, nc);
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, nr * nc);
      for (k = 0; k < n; k++) push_load(random_element());
      push_rect_query(nr, nc);
      push_rect_query(nr, nc);
    end
  endtask

  // ---------------- driver ----------------
  logic        took = 1'b0;
  int unsigned quiet = 0;

  always @(negedge clk) begin
    logic      nxt_start, nxt_we;
    bench_op_t s;
    if (rst_n) begin
      nxt_start = start && !took;
      nxt_we    = 1'b0;
      if (!nxt_start && pending_ops.size() != 0) begin
        s = pending_ops[0];
        if (s.is_reg) begin
          // register writes only once the block has gone quiet
          if (quiet >= SETTLE_CYCLES) begin
            cfg_index <= s.reg_idx;
            cfg_data  <= s.reg_val;
            nxt_we    = 1'b1;
            pending_ops.delete(0);
          end
        end else if ($urandom_range(0, 99) >= s.gap_pct) begin
          in_op            <= s.op;
          in_element_value <= s.elem;
          in_top_row       <= s.top;
          in_left_col      <= s.left;
          in_bottom_row    <= s.bottom;
          in_right_col     <= s.right;
          nxt_start        = 1'b1;
          pending_ops.delete(0);
        end
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // ---------------- monitor ----------------
  rect_answer_t rect_sums_due[$];
  int unsigned  fail_count = 0;

  task automatic note_mismatch(string what, rect_answer_t want);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t %s: expected sum %0d err %0b, got sum %0d err %0b", $time, what,
               want.sum, want.err, out_rect_sum, out_query_error);
  endtask

  always @(posedge clk) begin
    rect_answer_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (rect_sums_due.size() == 0) begin
          note_mismatch("result with none due", '0);
        end else begin
          want = rect_sums_due.pop_front();
          if (out_rect_sum !== want.sum || out_query_error !== want.err)
            note_mismatch("rectangle sum mismatch", want);
        end
      end
      if (cfg_we) apply_reg_write(cfg_index, cfg_data);
      if (start && !busy) begin
        if (in_op == OP_QUERY)
          rect_sums_due.push_back(rect_answer(in_top_row, in_left_col, in_bottom_row,
                                              in_right_col));
        else
          absorb_element(in_element_value);
      end
      took <= start && !busy;
      // a load leaves no result behind, so count idle cycles before resizing
      if (start || busy || rect_sums_due.size() != 0) quiet <= 0;
      else if (quiet < 10000) quiet <= quiet + 1;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int unsigned k;
    // table incomplete right after reset and after a single load
    push_query(0, 0, 0, 0);
    push_load(16'sd32767);
    push_query(0, 0, 0, 0);
    // 2 x 3 table with extreme elements
    push_reg(REG_ROW_COUNT, 7'd2);
    push_reg(REG_COL_COUNT, 7'd3);
    push_load({1'b1, {(EW-1){1'b0}}});
    push_load({1'b0, {(EW-1){1'b1}}});
    push_load('1);
    push_load('0);
    push_load(16'sd1);
    push_load({1'b1, {(EW-1){1'b0}}});
    push_query(0, 0, 1, 2);
    push_query(0, 0, 0, 0);
    push_query(1, 2, 1, 2);
    push_query(0, 1, 1, 2);
    push_query(1, 0, 1, 2);
    push_query(1, 0, 0, 2);
    push_query(0, 2, 1, 1);
    push_query(0, 0, 2, 2);
    push_query(0, 0, 1, 3);
    push_query(63, 63, 63, 63);
    // writes to unused indexes must leave the table intact
    push_reg(REG_SPARE_2, 7'd5);
    push_reg(REG_SPARE_3, 7'd127);
    push_query(0, 0, 1, 2);
    // one more load starts a fresh table
    push_load(16'sd100);
    push_query(0, 0, 0, 0);

    // extreme sizes, zero and oversize register values
    fill_round(7'd0, 7'd127);
    fill_round(7'd65, 7'd1);
    while (items_queued < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1))
          fill_round(CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(0, 2)));
        else
          fill_round(CFG_W'($urandom_range(0, 2)), CFG_W'($urandom_range(0, 127)));
      end else begin
        fill_round(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || start) @(posedge clk);
    k = 0;
    while (rect_sums_due.size() != 0 && k < 200) begin
      @(posedge clk);
      k++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += rect_sums_due.size();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: rectangle_sum_prefix_table_top.f
hw/rtl/rspt_pkg.sv
hw/rtl/rectangle_sum_prefix_table_top.sv
hw/rtl/rspt_checker.sv
sim/rectangle_sum_prefix_table_top_test.sv
